// ===== hdl/c_string_escaper_defines.svh =====
// assertion macros for the c string escaper
`ifndef C_STRING_ESCAPER_DEFINES_SVH
`define C_STRING_ESCAPER_DEFINES_SVH

`ifndef SYNTHESIS
`define CSE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define CSE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define CSE_ASSERT(lbl, clk, rstn, prop, msg)
`define CSE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hdl/cse_pkg.sv =====
// shared types, constants and escape helpers for the c string escaper
package cse_pkg;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChQmark  = 8'h3F;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoF    = 8'h66;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] PrintLo  = 8'h20;
  localparam logic [7:0] PrintHi  = 8'h7E;
  localparam logic [15:0] WideLo  = 16'h0100;

  typedef enum logic [2:0] {
    KindPlain,
    KindQuote,
    KindCtrl,
    KindOct1,
    KindHex,
    KindOct3,
    KindUni
  } cse_kind_e;

  typedef struct packed {
    cse_kind_e   kind;
    logic [15:0] code;
    logic        run_last;
    logic        text_last;
  } cse_job_t;

  function automatic logic [15:0] cse_mask(logic [15:0] c, logic wide);
    return wide ? c : {8'h00, c[7:0]};
  endfunction

  function automatic logic cse_is_oct(logic [15:0] c);
    return (c >= 16'(ChZero)) && (c <= 16'(ChSeven));
  endfunction

  function automatic logic cse_is_hex(logic [15:0] c);
    return ((c >= 16'(ChZero)) && (c <= 16'(ChNine))) ||
           ((c >= 16'(ChUpA)) && (c <= 16'(ChUpF))) ||
           ((c >= 16'(ChLoA)) && (c <= 16'(ChLoF)));
  endfunction

  // pick the escape form of c given the code after it
  function automatic cse_kind_e cse_classify(logic [15:0] c_raw, logic [15:0] nx_raw,
                                             logic wide);
    logic [15:0] c;
    logic [15:0] nx;
    cse_kind_e   k;
    c  = cse_mask(c_raw, wide);
    nx = cse_mask(nx_raw, wide);
    if (c >= WideLo) begin
      k = KindUni;
    end else if ((c == 16'(ChQuote)) || (c == 16'(ChBslash))) begin
      k = KindQuote;
    end else if ((c >= 16'(PrintLo)) && (c <= 16'(PrintHi)) &&
                 !((c == 16'(ChQmark)) && (nx == 16'(ChQmark)))) begin
      k = KindPlain;
    end else if ((c == 16'(ChCr)) || (c == 16'(ChLf)) || (c == 16'(ChTab))) begin
      k = KindCtrl;
    end else if ((c < 16'd8) && !cse_is_oct(nx)) begin
      k = KindOct1;
    end else if (!cse_is_hex(nx)) begin
      k = KindHex;
    end else begin
      k = KindOct3;
    end
    return k;
  endfunction

  function automatic logic [2:0] cse_len(cse_kind_e k);
    logic [2:0] n;
    case (k)
      KindPlain: n = 3'd1;
      KindQuote: n = 3'd2;
      KindCtrl:  n = 3'd2;
      KindOct1:  n = 3'd2;
      KindHex:   n = 3'd4;
      KindOct3:  n = 3'd4;
      KindUni:   n = 3'd6;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] cse_hex_digit(logic [3:0] v);
    return (v < 4'd10) ? (ChZero + {4'h0, v}) : (ChSeven + {4'h0, v});
  endfunction

  function automatic logic [7:0] cse_oct_digit(logic [2:0] v);
    return ChZero + {5'h00, v};
  endfunction

endpackage

// ===== hdl/c_string_escaper.sv =====
// top level of the c string escaper
// Escapes a character stream into C string literal form. Input and output
// are queue style: a beat goes in when push is high and full is low, and a
// result leaves when pop is high and empty is low. Each character is held
// until the next one arrives, since its escape depends on that successor; a
// beat with end_of_text flushes it and is escaped with a zero successor. The
// front end takes one beat per cycle while the job queue has room, except
// that a beat closing a text behind a held character queues two jobs and so
// keeps full high until the second is queued. The back end emits one output
// character per cycle while pop keeps up, 1 to 6 per input by its escape.
// The user must write wide_mode only while the block is idle (the block
// does not enforce it); it takes effect on the next escape decision.
module c_string_escaper import cse_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wide_mode_we_i,
  input  logic        wide_mode_i,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_char_i,
  input  logic        end_of_text_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_char_o,
  output logic        run_last_o,
  output logic        text_last_o
);

  logic     wide_mode_q;
  logic     job_push, job_full, job_pop, job_empty;
  cse_job_t job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_mode_q <= 1'b0;
    end else if (wide_mode_we_i) begin
      wide_mode_q <= wide_mode_i;
    end
  end

  cse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wide_mode_i   (wide_mode_q),
    .push_i        (push),
    .full_o        (full),
    .in_char_i     (in_char_i),
    .end_of_text_i (end_of_text_i),
    .job_full_i    (job_full),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  cse_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  cse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o),
    .text_last_o (text_last_o)
  );

endmodule

// ===== hdl/cse_front.sv =====
// front end: holds one character back, classifies escapes and queues jobs
module cse_front import cse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wide_mode_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [15:0] in_char_i,
  input  logic        end_of_text_i,
  input  logic        job_full_i,
  output logic        job_push_o,
  output cse_job_t    job_o
);

  logic        held_valid_q, held_valid_d;
  logic [15:0] held_char_q, held_char_d;
  logic        pend_q, pend_d;
  cse_job_t    pend_job_q, pend_job_d;
  logic        accept;
  cse_job_t    held_job, eot_job;

  assign full_o = pend_q | job_full_i;
  assign accept = push_i & ~full_o;

  always_comb begin
    held_job.kind      = cse_classify(held_char_q, in_char_i, wide_mode_i);
    held_job.code      = cse_mask(held_char_q, wide_mode_i);
    held_job.run_last  = ~end_of_text_i;
    held_job.text_last = 1'b0;
    eot_job.kind       = cse_classify(in_char_i, 16'h0000, wide_mode_i);
    eot_job.code       = cse_mask(in_char_i, wide_mode_i);
    eot_job.run_last   = 1'b1;
    eot_job.text_last  = 1'b1;
  end

  always_comb begin
    held_valid_d = held_valid_q;
    held_char_d  = held_char_q;
    pend_d       = pend_q;
    pend_job_d   = pend_job_q;
    job_push_o   = 1'b0;
    job_o        = eot_job;
    if (pend_q) begin
      // second job of a beat that closed a text
      job_o = pend_job_q;
      if (!job_full_i) begin
        job_push_o = 1'b1;
        pend_d     = 1'b0;
      end
    end else if (accept) begin
      if (held_valid_q) begin
        job_o      = held_job;
        job_push_o = 1'b1;
        if (end_of_text_i) begin
          pend_d     = 1'b1;
          pend_job_d = eot_job;
        end
      end else if (end_of_text_i) begin
        job_o      = eot_job;
        job_push_o = 1'b1;
      end
      if (end_of_text_i) begin
        held_valid_d = 1'b0;
        held_char_d  = 16'h0000;
      end else begin
        held_valid_d = 1'b1;
        held_char_d  = in_char_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_char_q  <= 16'h0000;
      pend_q       <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      held_char_q  <= held_char_d;
      pend_q       <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_job_q <= pend_job_d;
  end

endmodule

// ===== hdl/cse_fifo.sv =====
// job queue between the front end and the back end
`include "c_string_escaper_defines.svh"
module cse_fifo import cse_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cse_job_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output cse_job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cse_job_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `CSE_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push_i, !full_o, "job pushed into full queue")
  `CSE_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, !empty_o, "job popped from empty queue")
  `CSE_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CntW'(Depth), "job count above depth")

endmodule

// ===== hdl/cse_back.sv =====
// back end: expands one job into its escape characters, one per cycle while pop keeps up
`include "c_string_escaper_defines.svh"
module cse_back import cse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_empty_i,
  input  cse_job_t    job_i,
  output logic        job_pop_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] out_char_o,
  output logic        run_last_o,
  output logic        text_last_o
);

  logic        out_valid_q;
  logic [15:0] out_char_q;
  logic        run_last_q, text_last_q;
  logic [2:0]  idx_q;
  logic [2:0]  len;
  logic        last, load;
  logic [7:0]  ch;
  logic [15:0] c;

  assign c    = job_i.code;
  assign len  = cse_len(job_i.kind);
  assign last = (idx_q == (len - 3'd1));
  assign load = ~job_empty_i & (~out_valid_q | pop_i);
  assign job_pop_o = load & last;

  always_comb begin
    ch = ChBslash;
    case (job_i.kind)
      KindPlain: ch = c[7:0];
      KindQuote: ch = (idx_q == 3'd0) ? ChBslash : c[7:0];
      KindCtrl: begin
        if (idx_q == 3'd0) begin
          ch = ChBslash;
        end else if (c[7:0] == ChCr) begin
          ch = ChR;
        end else if (c[7:0] == ChLf) begin
          ch = ChN;
        end else begin
          ch = ChT;
        end
      end
      KindOct1: ch = (idx_q == 3'd0) ? ChBslash : cse_oct_digit(c[2:0]);
      KindHex: begin
        case (idx_q)
          3'd0:    ch = ChBslash;
          3'd1:    ch = ChX;
          3'd2:    ch = cse_hex_digit(c[7:4]);
          default: ch = cse_hex_digit(c[3:0]);
        endcase
      end
      KindOct3: begin
        case (idx_q)
          3'd0:    ch = ChBslash;
          3'd1:    ch = cse_oct_digit({1'b0, c[7:6]});
          3'd2:    ch = cse_oct_digit(c[5:3]);
          default: ch = cse_oct_digit(c[2:0]);
        endcase
      end
      KindUni: begin
        case (idx_q)
          3'd0:    ch = ChBslash;
          3'd1:    ch = ChU;
          3'd2:    ch = cse_hex_digit(c[15:12]);
          3'd3:    ch = cse_hex_digit(c[11:8]);
          3'd4:    ch = cse_hex_digit(c[7:4]);
          default: ch = cse_hex_digit(c[3:0]);
        endcase
      end
      default: ch = ChBslash;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? 3'd0 : idx_q + 3'd1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q  <= {8'h00, ch};
      run_last_q  <= job_i.run_last & last;
      text_last_q <= job_i.text_last & last;
    end
  end

  assign empty_o     = ~out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = run_last_q;
  assign text_last_o = text_last_q;

  `CSE_ASSERT_IMPL(a_idx_has_job, clk_i, rst_ni, idx_q != 3'd0, !job_empty_i, "escape in progress without a job")

endmodule
